[rtl/atpt_pkg.sv]
// Shared widths, angle constants and the CORDIC arctangent table for the
// pan/tilt aiming pipeline. No dependencies.
`default_nettype none
package atpt_pkg;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = 33;
   localparam int ROLL_W   = 24;
   localparam int RADIUS_W = 31;
   localparam int R2_W     = 62;
   localparam int SUM_W    = 66;
   localparam int ROOT_W   = 33;
   localparam int PV_W     = 34;
   localparam int CW       = 38;
   localparam int ZW       = 26;
   localparam int PAN_W    = 17;
   localparam int TILT_W   = 16;

   localparam int HALF_TURN    = 46080;
   localparam int FULL_TURN    = 92160;
   localparam int QUARTER_TURN = 23040;
   localparam int Z_QUARTER    = 90 * 65536;
   localparam int ROUND_HALF   = 128;
   localparam int ROUND_SHIFT  = 8;

   typedef struct packed {
      logic signed [PV_W-1:0]   px;
      logic signed [PV_W-1:0]   py;
      logic signed [ZW-1:0]     z0;
      logic signed [DIFF_W-1:0] dy;
      logic signed [ROLL_W-1:0] roll;
      logic                     outside;
      logic                     nz;
   } isq_side_type;

   typedef struct packed {
      logic signed [ROLL_W-1:0] roll;
      logic                     outside;
   } tilt_side_type;

   // atan(2^-s) in 1/65536 degree
   function automatic logic signed [ZW-1:0] atan_fine(input int s);
      logic signed [ZW-1:0] r;
      case (s)
         0:  r = ZW'(2949120);
         1:  r = ZW'(1740967);
         2:  r = ZW'(919879);
         3:  r = ZW'(466945);
         4:  r = ZW'(234379);
         5:  r = ZW'(117304);
         6:  r = ZW'(58666);
         7:  r = ZW'(29335);
         8:  r = ZW'(14668);
         9:  r = ZW'(7334);
         10: r = ZW'(3667);
         11: r = ZW'(1833);
         12: r = ZW'(917);
         13: r = ZW'(458);
         14: r = ZW'(229);
         15: r = ZW'(115);
         16: r = ZW'(57);
         17: r = ZW'(29);
         18: r = ZW'(14);
         19: r = ZW'(7);
         20: r = ZW'(4);
         21: r = ZW'(2);
         22: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/atpt_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside. Depends on atpt_pkg.
`default_nettype none
module atpt_isqrt
   import atpt_pkg::*;
#(
   parameter int SIDE_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [SUM_W-1:0]  in_sum,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output logic [SIDE_W-1:0]      out_side
);

   logic [SUM_W-1:0]  rem_ff  [0:ROOT_W-2];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];
   logic [SIDE_W-1:0] side_ff [0:ROOT_W-1];
   logic              v_ff    [0:ROOT_W-1];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [SUM_W-1:0]  cur_rem;
      logic [ROOT_W-1:0] cur_root;
      logic [SIDE_W-1:0] cur_side;
      logic              cur_v;
      logic [SUM_W:0]    trial;
      logic              take;
      logic [SUM_W:0]    rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign cur_rem  = in_sum;
         assign cur_root = '0;
         assign cur_side = in_side;
         assign cur_v    = in_valid;
      end else begin : g_next
         assign cur_rem  = rem_ff[k-1];
         assign cur_root = root_ff[k-1];
         assign cur_side = side_ff[k-1];
         assign cur_v    = v_ff[k-1];
      end

      always_comb begin
         trial   = ((SUM_W+1)'(cur_root) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
         take    = {1'b0, cur_rem} >= trial;
         rem_in  = take ? ({1'b0, cur_rem} - trial) : {1'b0, cur_rem};
         root_in = take ? (cur_root | (ROOT_W'(1) << B)) : cur_root;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= cur_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k] <= root_in;
            side_ff[k] <= cur_side;
         end
      end

      if (k < ROOT_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in[SUM_W-1:0];
            end
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

[rtl/atpt_cordic.sv]
// Pipelined CORDIC vectoring unit: one micro-rotation per register stage,
// accumulating the angle in 1/65536 degree. Depends on atpt_pkg.
`default_nettype none
module atpt_cordic
   import atpt_pkg::*;
#(
   parameter int STAGES = 20,
   parameter int SIDE_W = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] in_x,
   input  wire logic signed [CW-1:0] in_y,
   input  wire logic signed [ZW-1:0] in_z,
   input  wire logic [SIDE_W-1:0]    in_side,
   output logic                      out_valid,
   output logic signed [ZW-1:0]      out_z,
   output logic [SIDE_W-1:0]         out_side
);

   logic signed [CW-1:0] x_ff    [0:STAGES-2];
   logic signed [CW-1:0] y_ff    [0:STAGES-2];
   logic signed [ZW-1:0] z_ff    [0:STAGES-1];
   logic [SIDE_W-1:0]    side_ff [0:STAGES-1];
   logic                 v_ff    [0:STAGES-1];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int S = k % 32;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [ZW-1:0] cz;
      logic [SIDE_W-1:0]    cs;
      logic                 cv;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      if (k == 0) begin : g_first
         assign cx = in_x;
         assign cy = in_y;
         assign cz = in_z;
         assign cs = in_side;
         assign cv = in_valid;
      end else begin : g_next
         assign cx = x_ff[k-1];
         assign cy = y_ff[k-1];
         assign cz = z_ff[k-1];
         assign cs = side_ff[k-1];
         assign cv = v_ff[k-1];
      end

      always_comb begin
         if (cy > 0) begin
            x_in = cx + (cy >>> S);
            y_in = cy - (cx >>> S);
            z_in = cz + atan_fine(S);
         end else begin
            x_in = cx - (cy >>> S);
            y_in = cy + (cx >>> S);
            z_in = cz - atan_fine(S);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= cv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[k]    <= z_in;
            side_ff[k] <= cs;
         end
      end

      if (k < STAGES - 1) begin : g_xy
         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[k] <= x_in;
               y_ff[k] <= y_in;
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES-1];
   assign out_z     = z_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
`default_nettype wire

[rtl/aim_pan_tilt_from_points.sv]
// Top level of the look-at aiming pipeline: differences, squares, integer
// square root, two CORDIC units and output rounding. Depends on atpt_pkg,
// atpt_isqrt and atpt_cordic.
//
// Usage:
//  - req_* carries one pose request (nodal point, target point, roll);
//    rsp_* returns one result per request, in order.
//  - csr_* writes the safe cylinder radius (Q15.16 m); csr_ready is always
//    high. Write it only while no request is in flight.
//  - The pipeline has three front stages, 33 square
//    root stages (one root bit each), CORDIC_STAGES rotation stages and the
//    output register.
//  - Throughput is one request per cycle while rsp_tready is high.
//  - The whole pipeline advances on one enable: when the output register
//    holds a result that is not taken, every stage holds and req_tready
//    drops; nothing is lost or repeated.
//  - Reset clears all valid bits and sets the radius to zero.
`default_nettype none
module aim_pan_tilt_from_points
   import atpt_pkg::*;
#(
   parameter int CORDIC_STAGES = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // tdata: nodal_x, nodal_y, nodal_z, target_x, target_y, target_z, roll_in
   input  wire logic [215:0]  req_tdata,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tdata: pan, tilt, roll_out, outside_cylinder, zero fill
   output logic [63:0]        rsp_tdata,
   // tuser: valid_res
   output logic [0:0]         rsp_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [30:0]   csr_data,
   input  wire logic          csr_valid,
   output logic               csr_ready
);

   logic                 en;
   logic [RADIUS_W-1:0]  radius_ff;

   logic                 v1_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy1_ff, dz_ff;
   logic signed [ROLL_W-1:0] roll1_ff;

   logic [DIFF_W-1:0]    ax, az;
   logic signed [PV_W-1:0] px0, py0, px_in, py_in;
   logic signed [ZW-1:0] z0_in;

   logic                 v2_ff;
   logic [SUM_W-1:0]     sqx_ff, sqz_ff;
   logic [R2_W-1:0]      r2_ff;
   logic signed [PV_W-1:0] px_ff, py_ff;
   logic signed [ZW-1:0] z0_ff;
   logic signed [DIFF_W-1:0] dy2_ff;
   logic signed [ROLL_W-1:0] roll2_ff;

   logic                 v3_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SUM_W-1:0]     sum_in;
   isq_side_type         side3_ff;

   logic                 isq_v;
   logic [ROOT_W-1:0]    isq_root;
   isq_side_type         isq_side;

   logic                 pan_v, tilt_v;
   logic signed [ZW-1:0] pan_z, tilt_z;
   logic [0:0]           pan_side;
   tilt_side_type        tilt_side_in, tilt_side;

   logic signed [ZW-1:0] pan_r, tilt_r, pan_w, tilt_c;

   logic                 rsp_tvalid_ff;
   logic signed [PAN_W-1:0]  pan_ff;
   logic signed [TILT_W-1:0] tilt_ff;
   logic signed [ROLL_W-1:0] roll_ff;
   logic                 outside_ff;
   logic                 valid_res_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   // stage 1: differences
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff    <= DIFF_W'($signed(req_tdata[127:96])) - DIFF_W'($signed(req_tdata[31:0]));
         dy1_ff   <= DIFF_W'($signed(req_tdata[159:128])) - DIFF_W'($signed(req_tdata[63:32]));
         dz_ff    <= DIFF_W'($signed(req_tdata[191:160])) - DIFF_W'($signed(req_tdata[95:64]));
         roll1_ff <= $signed(req_tdata[215:192]);
      end
   end

   // stage 2: squares, radius square, pan quadrant fold
   always_comb begin
      ax  = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
      az  = dz_ff[DIFF_W-1] ? DIFF_W'(-dz_ff) : DIFF_W'(dz_ff);
      px0 = -PV_W'(dz_ff);
      py0 = -PV_W'(dx_ff);
      if (px0 < 0) begin
         if (py0 >= 0) begin
            px_in = py0;
            py_in = -px0;
            z0_in = ZW'(Z_QUARTER);
         end else begin
            px_in = -py0;
            py_in = px0;
            z0_in = -ZW'(Z_QUARTER);
         end
      end else begin
         px_in = px0;
         py_in = py0;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= SUM_W'(ax) * SUM_W'(ax);
         sqz_ff   <= SUM_W'(az) * SUM_W'(az);
         r2_ff    <= R2_W'(radius_ff) * R2_W'(radius_ff);
         px_ff    <= px_in;
         py_ff    <= py_in;
         z0_ff    <= z0_in;
         dy2_ff   <= dy1_ff;
         roll2_ff <= roll1_ff;
      end
   end

   // stage 3: sum of squares, radius compare
   assign sum_in = sqx_ff + sqz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff           <= sum_in;
         side3_ff.px      <= px_ff;
         side3_ff.py      <= py_ff;
         side3_ff.z0      <= z0_ff;
         side3_ff.dy      <= dy2_ff;
         side3_ff.roll    <= roll2_ff;
         side3_ff.outside <= sum_in > SUM_W'(r2_ff);
         side3_ff.nz      <= sum_in != '0;
      end
   end

   atpt_isqrt #(
      .SIDE_W ($bits(isq_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_sum    (sum_ff),
      .in_side   (side3_ff),
      .out_valid (isq_v),
      .out_root  (isq_root),
      .out_side  (isq_side)
   );

   assign tilt_side_in.roll    = isq_side.roll;
   assign tilt_side_in.outside = isq_side.outside;

   atpt_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (1)
   ) u_pan_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (isq_v),
      .in_x      (CW'(isq_side.px)),
      .in_y      (CW'(isq_side.py)),
      .in_z      (isq_side.z0),
      .in_side   (isq_side.nz),
      .out_valid (pan_v),
      .out_z     (pan_z),
      .out_side  (pan_side)
   );

   atpt_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W ($bits(tilt_side_type))
   ) u_tilt_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (isq_v),
      .in_x      ($signed(CW'(isq_root))),
      .in_y      (CW'(isq_side.dy)),
      .in_z      ('0),
      .in_side   (tilt_side_in),
      .out_valid (tilt_v),
      .out_z     (tilt_z),
      .out_side  (tilt_side)
   );

   // output stage: round, wrap pan, clamp tilt
   always_comb begin
      pan_r  = (pan_z + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;
      tilt_r = (tilt_z + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;
      if (pan_r >= ZW'(HALF_TURN)) begin
         pan_w = pan_r - ZW'(FULL_TURN);
      end else if (pan_r < -ZW'(HALF_TURN)) begin
         pan_w = pan_r + ZW'(FULL_TURN);
      end else begin
         pan_w = pan_r;
      end
      if (tilt_r > ZW'(QUARTER_TURN)) begin
         tilt_c = ZW'(QUARTER_TURN);
      end else if (tilt_r < -ZW'(QUARTER_TURN)) begin
         tilt_c = -ZW'(QUARTER_TURN);
      end else begin
         tilt_c = tilt_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= tilt_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         valid_res_ff <= pan_side[0];
         pan_ff       <= pan_side[0] ? PAN_W'(pan_w) : '0;
         tilt_ff      <= pan_side[0] ? TILT_W'(tilt_c) : '0;
         roll_ff      <= tilt_side.roll;
         outside_ff   <= tilt_side.outside;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = valid_res_ff;
   assign rsp_tdata  = {6'd0, outside_ff, roll_ff, tilt_ff, pan_ff};

   a_units_aligned: assert property (@(posedge clock) disable iff (reset)
      pan_v == tilt_v)
      else $error("pan and tilt units out of step");

   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !valid_res_ff |-> pan_ff == '0 && tilt_ff == '0)
      else $error("angles nonzero for zero horizontal distance");

   a_pan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> pan_ff >= -PAN_W'(HALF_TURN) && pan_ff <= PAN_W'(HALF_TURN - 1))
      else $error("pan out of range");

   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> tilt_ff >= -TILT_W'(QUARTER_TURN) && tilt_ff <= TILT_W'(QUARTER_TURN))
      else $error("tilt out of range");

endmodule
`default_nettype wire
